// ===== rtl/bcv_pkg.sv =====
// Package for the blit command validator: memory map constants, opcodes,
// register indexes and the payload types passed between pipeline stages.
// No dependencies.
package bcv_pkg;

  localparam logic [31:0] MemLow  = 32'h3000_0000;
  localparam logic [33:0] MemEnd  = 34'h0_4000_0000;
  localparam logic [31:0] RingLow = 32'h3002_0000;
  localparam logic [31:0] RingEnd = 32'h3002_2800;
  localparam logic [31:0] DimMax  = 32'd65535;
  localparam logic [32:0] KibMask = 33'd1023;

  localparam logic [31:0] OPC_FILL    = 32'd1;
  localparam logic [31:0] OPC_COPY    = 32'd2;
  localparam logic [31:0] OPC_KEYED   = 32'd3;
  localparam logic [31:0] OPC_PRESENT = 32'd4;
  localparam logic [31:0] OPC_SPRITES = 32'd5;
  localparam logic [31:0] OPC_LOAD    = 32'd6;

  localparam logic [1:0] CFG_SPRITE_BASE  = 2'd0;
  localparam logic [1:0] CFG_SPRITE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd2;

  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_FILL,
    KIND_COPY,
    KIND_KEYED,
    KIND_PRESENT,
    KIND_SPRITES,
    KIND_LOAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        pre_ok;
    logic [31:0] dst_base;
    logic [31:0] dst_prod;
    logic [17:0] dst_row;
    logic [31:0] src_base;
    logic [31:0] src_prod;
    logic [31:0] load_dst;
    logic [32:0] load_len;
    logic [31:0] load_src;
  } s1_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        pre_ok;
    logic [31:0] dst_base;
    logic [32:0] dst_len;
    logic [31:0] src_base;
    logic [32:0] src_len;
    logic [33:0] load_win_stop;
    logic [31:0] load_src;
    logic [32:0] load_len;
    logic [33:0] load_stop;
  } s2_t;

endpackage

// ===== rtl/blit_command_validator_core.sv =====
// Blit command validator: three-stage pipeline checking one eight-word command.
// One item per cycle is accepted while the output is not stalled, and each
// stage advances on its own so bubbles close under stall.
// The depth is set by the row multiply, the span add and the bound compare.
// Synchronous reset empties the pipeline and loads the register defaults.
// Depends on bcv_pkg and the three bcv stage modules.
module blit_command_validator_core
  import bcv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0: opcode, word_one, word_two, word_three, word_four,
  // word_five, word_six, word_seven.
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0: command_ok, then zero fill.
  output logic [7:0]   m_axis_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [32:0]  cfg_data
);

  logic [31:0] sprite_base;
  logic [15:0] sprite_limit;
  logic [32:0] window_size;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s2_valid;
  logic s2_ready;
  s2_t  s2_data;
  logic ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_base  <= 32'd0;
      sprite_limit <= 16'd256;
      window_size  <= 33'd33554432;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPRITE_BASE:  sprite_base  <= cfg_data[31:0];
        CFG_SPRITE_LIMIT: sprite_limit <= cfg_data[15:0];
        CFG_WINDOW_SIZE:  window_size  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bcv_decode_stage u_decode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_data      (s_axis_tdata),
    .sprite_base  (sprite_base),
    .sprite_limit (sprite_limit),
    .out_valid    (s1_valid),
    .out_ready    (s1_ready),
    .out_data     (s1_data)
  );

  bcv_length_stage u_length (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  bcv_bound_stage u_bound (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s2_valid),
    .in_ready    (s2_ready),
    .in_data     (s2_data),
    .window_size (window_size),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_ok      (ok)
  );

  assign m_axis_tdata = {7'd0, ok};

endmodule

// ===== rtl/bcv_decode_stage.sv =====
// First pipeline stage: opcode decode, operand checks, row products and
// rounded load length. Depends on bcv_pkg.
module bcv_decode_stage
  import bcv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [255:0] in_data,
  input  logic [31:0]  sprite_base,
  input  logic [15:0]  sprite_limit,
  output logic         out_valid,
  input  logic         out_ready,
  output s1_t          out_data
);

  logic [31:0] w [8];
  logic        dst_basic;
  logic        src_basic;
  logic [15:0] ht_less;
  cmd_kind_t   kind;
  s1_t         next;

  function automatic logic rect_basic(input logic [31:0] addr, input logic [31:0] pitch,
                                      input logic [31:0] wd, input logic [31:0] ht);
    logic [31:0] row;
    row = {14'd0, wd[15:0], 2'b00};
    return (wd != 32'd0) && (ht != 32'd0) && (wd <= DimMax) && (ht <= DimMax) &&
           (pitch <= DimMax) && (pitch[1:0] == 2'b00) && (addr[1:0] == 2'b00) &&
           (pitch >= row);
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      w[i] = in_data[32*i +: 32];
    end
  end

  always_comb begin
    unique case (w[0])
      OPC_FILL:    kind = KIND_FILL;
      OPC_COPY:    kind = KIND_COPY;
      OPC_KEYED:   kind = KIND_KEYED;
      OPC_PRESENT: kind = KIND_PRESENT;
      OPC_SPRITES: kind = KIND_SPRITES;
      OPC_LOAD:    kind = KIND_LOAD;
      default:     kind = KIND_BAD;
    endcase
  end

  assign dst_basic = rect_basic(w[1], w[2], w[3], w[4]);
  assign src_basic = rect_basic(w[6], w[7], w[3], w[4]);
  assign ht_less   = w[4][15:0] - 16'd1;

  always_comb begin
    next.kind     = kind;
    next.dst_base = w[1];
    next.dst_prod = {16'd0, ht_less} * {16'd0, w[2][15:0]};
    next.dst_row  = {w[3][15:0], 2'b00};
    next.src_base = w[6];
    next.src_prod = {16'd0, ht_less} * {16'd0, w[7][15:0]};
    next.load_dst = w[1];
    next.load_len = ({1'b0, w[5]} + KibMask) & ~KibMask;
    next.load_src = w[6];
    unique case (kind)
      KIND_FILL:    next.pre_ok = (w[6] == 32'd0) && (w[7] == 32'd0) && dst_basic;
      KIND_COPY:    next.pre_ok = (w[5] == 32'd0) && dst_basic && src_basic;
      KIND_KEYED:   next.pre_ok = dst_basic && src_basic;
      KIND_PRESENT: next.pre_ok = (w[1] | w[2] | w[3] | w[4] | w[5] | w[6] | w[7]) == 32'd0;
      KIND_SPRITES: next.pre_ok = (w[1] == sprite_base) && (w[3] != 32'd0) &&
                                  (w[3] <= {16'd0, sprite_limit}) &&
                                  ((w[2] | w[4] | w[5] | w[6] | w[7]) == 32'd0);
      KIND_LOAD:    next.pre_ok = ((w[2] | w[3] | w[4] | w[7]) == 32'd0) &&
                                  (w[5] != 32'd0) && (w[1][9:0] == 10'd0) &&
                                  (w[6][2:0] == 3'd0);
      default:      next.pre_ok = 1'b0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= next;
    end
  end

endmodule

// ===== rtl/bcv_length_stage.sv =====
// Second pipeline stage: rectangle byte spans and load end addresses.
// Depends on bcv_pkg.
module bcv_length_stage
  import bcv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  s1_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output s2_t  out_data
);

  s2_t next;

  always_comb begin
    next.kind          = in_data.kind;
    next.pre_ok        = in_data.pre_ok;
    next.dst_base      = in_data.dst_base;
    next.dst_len       = {1'b0, in_data.dst_prod} + {15'd0, in_data.dst_row};
    next.src_base      = in_data.src_base;
    next.src_len       = {1'b0, in_data.src_prod} + {15'd0, in_data.dst_row};
    next.load_win_stop = {2'b00, in_data.load_dst} + {1'b0, in_data.load_len};
    next.load_src      = in_data.load_src;
    next.load_len      = in_data.load_len;
    next.load_stop     = {2'b00, in_data.load_src} + {1'b0, in_data.load_len};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= next;
    end
  end

endmodule

// ===== rtl/bcv_bound_stage.sv =====
// Third pipeline stage: window and ring bound checks, final verdict register.
// Depends on bcv_pkg.
module bcv_bound_stage
  import bcv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  s2_t         in_data,
  input  logic [32:0] window_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok
);

  logic [33:0] dst_stop;
  logic [33:0] src_stop;
  logic        dst_span;
  logic        src_span;
  logic        load_span;
  logic        ok_next;

  function automatic logic span_ok(input logic [31:0] start, input logic [32:0] len,
                                   input logic [33:0] stop);
    return (len != 33'd0) && (start >= MemLow) && (stop <= MemEnd) &&
           !((start < RingEnd) && (stop > {2'b00, RingLow}));
  endfunction

  assign dst_stop  = {2'b00, in_data.dst_base} + {1'b0, in_data.dst_len};
  assign src_stop  = {2'b00, in_data.src_base} + {1'b0, in_data.src_len};
  assign dst_span  = span_ok(in_data.dst_base, in_data.dst_len, dst_stop);
  assign src_span  = span_ok(in_data.src_base, in_data.src_len, src_stop);
  assign load_span = span_ok(in_data.load_src, in_data.load_len, in_data.load_stop) &&
                     (in_data.load_win_stop <= {1'b0, window_size});

  always_comb begin
    unique case (in_data.kind)
      KIND_FILL:    ok_next = in_data.pre_ok && dst_span;
      KIND_COPY:    ok_next = in_data.pre_ok && dst_span && src_span;
      KIND_KEYED:   ok_next = in_data.pre_ok && dst_span && src_span;
      KIND_PRESENT: ok_next = in_data.pre_ok;
      KIND_SPRITES: ok_next = in_data.pre_ok;
      KIND_LOAD:    ok_next = in_data.pre_ok && load_span;
      default:      ok_next = 1'b0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_ok <= ok_next;
    end
  end

endmodule

// ===== tb/tb_blit_command_validator_core.sv =====
// Self-checking testbench for blit_command_validator_core: drives eight-word commands
// with random stalls on both streams and compares each verdict with a predicted one.
// Depends on bcv_pkg and the validator RTL.
`timescale 1ns / 100ps

module tb_blit_command_validator_core
  import bcv_pkg::*;
;

  localparam int PipeLatency = 3;
  localparam int WatchdogLimit = 2000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] word_seven, word_six, word_five, word_four;
    logic [31:0] word_three, word_two, word_one, opcode;
  } blit_cmd_t;

  typedef struct {
    blit_cmd_t   cmd;
    bit          ok;
    int unsigned seq;
  } verdict_t;

  class verdict_board;
    logic [31:0] sprite_base;
    logic [15:0] sprite_limit;
    logic [32:0] window_size;
    verdict_t    awaited[$];
    int unsigned accepted;
    int unsigned mismatches;

    function new();
      sprite_base = '0;
      sprite_limit = 16'd256;
      window_size = 33'd33554432;
      accepted = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [32:0] value);
      case (index)
        CFG_SPRITE_BASE: sprite_base = value[31:0];
        CFG_SPRITE_LIMIT: sprite_limit = value[15:0];
        CFG_WINDOW_SIZE: window_size = value;
        default: ;
      endcase
    endfunction

    function bit span_fits(longint unsigned start, longint unsigned len);
      longint unsigned stop;
      stop = start + len;
      if (len == 0) return 1'b0;
      if (start < MemLow) return 1'b0;
      if (stop > MemEnd) return 1'b0;
      if (start < RingEnd && stop > RingLow) return 1'b0;
      return 1'b1;
    endfunction

    function bit rect_fits(longint unsigned addr, longint unsigned pitch,
                           longint unsigned w, longint unsigned h);
      if (w == 0 || h == 0) return 1'b0;
      if (w > DimMax || h > DimMax || pitch > DimMax) return 1'b0;
      if (pitch[1:0] != 2'b00 || addr[1:0] != 2'b00) return 1'b0;
      if (pitch < w * 4) return 1'b0;
      return span_fits(addr, (h - 1) * pitch + w * 4);
    endfunction

    function bit predict_verdict(blit_cmd_t c);
      bit ok;
      longint unsigned len;
      longint unsigned dst;
      ok = 1'b0;
      case (c.opcode)
        OPC_FILL: begin
          ok = c.word_six == 0 && c.word_seven == 0 &&
               rect_fits(c.word_one, c.word_two, c.word_three, c.word_four);
        end
        OPC_COPY, OPC_KEYED: begin
          ok = (c.opcode != OPC_COPY || c.word_five == 0) &&
               rect_fits(c.word_one, c.word_two, c.word_three, c.word_four) &&
               rect_fits(c.word_six, c.word_seven, c.word_three, c.word_four);
        end
        OPC_PRESENT: begin
          ok = (c.word_one | c.word_two | c.word_three | c.word_four |
                c.word_five | c.word_six | c.word_seven) == 0;
        end
        OPC_SPRITES: begin
          ok = c.word_one == sprite_base && c.word_three >= 1 &&
               c.word_three <= sprite_limit &&
               (c.word_two | c.word_four | c.word_five | c.word_six | c.word_seven) == 0;
        end
        OPC_LOAD: begin
          len = c.word_five;
          len = (len + 1023) & ~64'd1023;
          dst = c.word_one;
          ok = (c.word_two | c.word_three | c.word_four | c.word_seven) == 0 &&
               c.word_five != 0 && c.word_one[9:0] == 0 && c.word_six[2:0] == 0 &&
               dst + len <= window_size && span_fits(c.word_six, len);
        end
        default: ok = 1'b0;
      endcase
      return ok;
    endfunction

    function void note_command(blit_cmd_t cmd);
      verdict_t v;
      v.cmd = cmd;
      v.ok = predict_verdict(cmd);
      v.seq = accepted;
      accepted++;
      awaited.push_back(v);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("error: %s", what);
    endtask

    task check_result(logic [7:0] result);
      verdict_t v;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("command_ok %0b arrived with no command pending",
                                  result[0]));
      end else begin
        v = awaited.pop_front();
        if (result[0] !== v.ok) begin
          report_mismatch($sformatf("item %0d: command_ok %0b, predicted %0b, command %h",
                                    v.seq, result[0], v.ok, v.cmd));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_valid = 1'b0;
  blit_cmd_t   s_data = '0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_SPRITE_BASE;
  logic [32:0] cfg_data = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [7:0]  m_axis_tdata;

  verdict_board sb = new();
  int sender_mode = 1;
  int receiver_mode = 1;
  int hold_request = 0;
  int stalled_cycles = 0;

  always #5 clk = ~clk;

  blit_command_validator_core i_dut (
    .clk,
    .rst,
    .s_axis_tvalid(s_valid),
    .s_axis_tready,
    .s_axis_tdata(s_data),
    .m_axis_tvalid,
    .m_axis_tready(m_ready),
    .m_axis_tdata,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [32:0] rand33();
    logic [32:0] r;
    r[31:0] = $urandom;
    r[32] = $urandom_range(0, 1);
    return r;
  endfunction

  function automatic blit_cmd_t make_cmd(logic [31:0] op, logic [31:0] a1, logic [31:0] a2,
                                         logic [31:0] a3, logic [31:0] a4, logic [31:0] a5,
                                         logic [31:0] a6, logic [31:0] a7);
    blit_cmd_t c;
    c.opcode = op;
    c.word_one = a1;
    c.word_two = a2;
    c.word_three = a3;
    c.word_four = a4;
    c.word_five = a5;
    c.word_six = a6;
    c.word_seven = a7;
    return c;
  endfunction

  // Places a span of the given size at random or near the window and ring edges.
  function automatic logic [31:0] place_span(longint unsigned span, longint unsigned align);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned pos;
    bit ranged;
    ranged = 1'b0;
    lo = 0;
    hi = 0;
    pos = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0, 1: begin
        lo = MemLow;
        hi = RingLow;
        ranged = span <= hi - lo;
        hi = hi - span;
      end
      2, 3, 4: begin
        lo = RingEnd;
        hi = MemEnd;
        ranged = span <= hi - lo;
        hi = hi - span;
      end
      5: pos = MemEnd - span;
      6: pos = RingLow - span;
      7: pos = RingEnd;
      8: pos = MemLow;
      9: pos = RingLow - span + align;
      10: pos = RingEnd - align;
      default: pos = ($urandom_range(0, 1) == 0) ? MemEnd - span + align : MemLow - align;
    endcase
    if (ranged) begin
      pos = lo + pos % (hi - lo + 1);
      pos = pos & ~(align - 1);
    end
    return pos[31:0];
  endfunction

  function automatic logic [31:0] pitch_for(logic [31:0] w);
    logic [31:0] p;
    p = 4 * w + 4 * $urandom_range(0, 8);
    if (p > 32'd65532) p = 4 * w;
    return p;
  endfunction

  function automatic blit_cmd_t random_cmd();
    blit_cmd_t c;
    logic [255:0] flat;
    logic [31:0] kinds [6];
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] pd;
    logic [31:0] ps;
    logic [31:0] len;
    longint unsigned span_d;
    longint unsigned span_s;
    longint unsigned round_len;
    longint unsigned tmp;
    longint unsigned r64;
    int k;
    kinds = '{OPC_FILL, OPC_COPY, OPC_KEYED, OPC_PRESENT, OPC_SPRITES, OPC_LOAD};
    c = '0;
    if ($urandom_range(0, 9) == 0) begin
      for (k = 0; k < 8; k++) flat[k*32 +: 32] = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      if ($urandom_range(0, 1) == 0) flat[31:0] = $urandom_range(0, 7);
      return flat;
    end
    c.opcode = kinds[$urandom_range(0, 5)];
    case ($urandom_range(0, 9))
      0: w = 32'd16383;
      1: w = $urandom_range(1, 16383);
      default: w = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 19))
      0: h = 32'd65535;
      1: h = $urandom_range(1, 65535);
      default: h = $urandom_range(1, 64);
    endcase
    pd = pitch_for(w);
    ps = pitch_for(w);
    span_d = h;
    span_d = (span_d - 1) * pd + 4 * w;
    span_s = h;
    span_s = (span_s - 1) * ps + 4 * w;
    case (c.opcode)
      OPC_FILL, OPC_COPY, OPC_KEYED: begin
        c.word_one = place_span(span_d, 4);
        c.word_two = pd;
        c.word_three = w;
        c.word_four = h;
        if (c.opcode == OPC_FILL) begin
          c.word_five = $urandom;
        end else begin
          c.word_five = (c.opcode == OPC_KEYED) ? $urandom : 32'd0;
          c.word_six = place_span(span_s, 4);
          c.word_seven = ps;
        end
      end
      OPC_SPRITES: begin
        c.word_one = sb.sprite_base;
        case ($urandom_range(0, 5))
          0: c.word_three = 32'd1;
          1: c.word_three = sb.sprite_limit;
          2: c.word_three = sb.sprite_limit + 32'd1;
          default: c.word_three = $urandom_range(1, sb.sprite_limit);
        endcase
      end
      OPC_LOAD: begin
        case ($urandom_range(0, 5))
          0: len = '1;
          1: len = $urandom;
          default: len = $urandom_range(1, 8192);
        endcase
        round_len = len;
        round_len = (round_len + 1023) & ~64'd1023;
        tmp = sb.window_size;
        r64 = $urandom;
        if ($urandom_range(0, 3) == 0) begin
          tmp = tmp - round_len + 1024 * $urandom_range(0, 1);
        end else begin
          tmp = (r64 % ((tmp >> 10) + 1)) << 10;
        end
        c.word_one = tmp[31:0];
        c.word_five = len;
        c.word_six = place_span(round_len, 8);
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      flat = c;
      k = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: flat[k*32 + $urandom_range(0, 31)] = ~flat[k*32 + $urandom_range(0, 31)];
        1: flat[k*32 +: 32] = $urandom;
        2: flat[k*32 +: 32] = '0;
        default: flat[k*32 +: 32] = '1;
      endcase
      c = flat;
    end
    return c;
  endfunction

  task automatic send_cmd(input blit_cmd_t c);
    int gap;
    gap = draw_gap(sender_mode);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= c;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.note_command(c);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (PipeLatency + 2) @(posedge clk);
  endtask

  task automatic configure(input logic [32:0] base, input logic [32:0] limit,
                           input logic [32:0] window);
    logic [32:0] junk;
    junk = rand33();
    cfg_we <= 1'b1;
    cfg_index <= CFG_SPRITE_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= CFG_SPRITE_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data <= window;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data <= junk;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_SPRITE_BASE, base);
    sb.set_register(CFG_SPRITE_LIMIT, limit);
    sb.set_register(CFG_WINDOW_SIZE, window);
    sb.set_register(CFG_UNUSED, junk);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) sender_mode = $urandom_range(0, 2);
      send_cmd(random_cmd());
    end
  endtask

  task automatic run_directed();
    send_cmd(make_cmd(OPC_FILL, MemLow, 4, 1, 1, '1, 0, 0));
    send_cmd(make_cmd(OPC_FILL, '1, '1, '1, '1, '1, '1, '1));
    send_cmd(make_cmd(OPC_FILL, RingEnd, 65532, 16383, 2, 0, 0, 0));
    send_cmd(make_cmd(OPC_FILL, RingEnd, 65532, 65535, 1, 0, 0, 0));
    send_cmd(make_cmd(OPC_FILL, RingEnd, 4, 1, 65535, 0, 0, 0));
    send_cmd(make_cmd(OPC_FILL, MemLow, 64, 16, 4, 0, 1, 0));
    send_cmd(make_cmd(OPC_FILL, 32'h3FFF_FFF0, 16, 4, 1, 0, 0, 0));
    send_cmd(make_cmd(OPC_FILL, RingLow - 64, 64, 16, 1, 0, 0, 0));
    send_cmd(make_cmd(OPC_FILL, RingEnd - 4, 64, 16, 1, 0, 0, 0));
    send_cmd(make_cmd(OPC_FILL, MemLow - 4, 4, 1, 1, 0, 0, 0));
    send_cmd(make_cmd(OPC_COPY, MemLow, 64, 16, 4, 0, RingEnd, 128));
    send_cmd(make_cmd(OPC_COPY, MemLow, 64, 16, 4, 1, RingEnd, 128));
    send_cmd(make_cmd(OPC_KEYED, MemLow, 64, 16, 4, '1, RingEnd, 128));
    send_cmd(make_cmd(OPC_PRESENT, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OPC_PRESENT, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
    send_cmd(make_cmd(OPC_SPRITES, 0, 0, 1, 0, 0, 0, 0));
    send_cmd(make_cmd(OPC_SPRITES, 0, 0, 256, 0, 0, 0, 0));
    send_cmd(make_cmd(OPC_SPRITES, 0, 0, 257, 0, 0, 0, 0));
    send_cmd(make_cmd(OPC_SPRITES, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OPC_LOAD, 0, 0, 0, 0, 1, MemLow, 0));
    send_cmd(make_cmd(OPC_LOAD, 512, 0, 0, 0, 1, MemLow, 0));
    send_cmd(make_cmd(OPC_LOAD, 0, 0, 0, 0, 1, MemLow + 4, 0));
    send_cmd(make_cmd(OPC_LOAD, 0, 0, 0, 0, 0, MemLow, 0));
    send_cmd(make_cmd(OPC_LOAD, 0, 0, 0, 0, '1, MemLow, 0));
    send_cmd(make_cmd(0, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd('1, MemLow, 4, 1, 1, 0, 0, 0));
  endtask

  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken % 40 == 0) receiver_mode = $urandom_range(0, 2);
      if (hold_request > 0) begin
        gap = hold_request;
        hold_request = 0;
      end else begin
        gap = draw_gap(receiver_mode);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tdata);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WatchdogLimit) begin
        $display("watchdog: no item moved for %0d cycles", WatchdogLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : command_source
    logic [32:0] limit;
    logic [32:0] window;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    sender_mode = 2;
    run_directed();
    run_random(220);
    drain();

    configure({1'b1, 32'hFFFF_FFFF}, 33'h1_FFFF_FFFF, 33'h1_0000_0000);
    run_random(220);
    drain();

    limit = rand33();
    limit[15:0] = 16'd1;
    configure(rand33(), limit, 33'd0);
    // Hold the result side off while commands keep coming, so the pipeline backs up.
    sender_mode = 0;
    hold_request = 300;
    repeat (40) send_cmd(random_cmd());
    run_random(180);
    drain();

    limit = rand33();
    limit[15:0] = $urandom_range(2, 65534);
    window = {1'b0, $urandom};
    configure(rand33(), limit, window);
    run_random(220);
    drain();

    limit = rand33();
    limit[15:0] = 16'd256;
    configure(33'd0, limit, 33'd33554432);
    run_random(240);
    drain();

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bcv_pkg.sv
rtl/bcv_decode_stage.sv
rtl/bcv_length_stage.sv
rtl/bcv_bound_stage.sv
rtl/blit_command_validator_core.sv
tb/tb_blit_command_validator_core.sv
